// ===== sv/itra_pkg.sv =====
// ----------------------------------------------------------------------------
// itra_pkg: shared definitions for the integer to radix ASCII converter
// Widths, character codes, register decode and digit helper functions.
// ----------------------------------------------------------------------------
package itra_pkg;

  localparam int DataW     = 32;
  localparam int RadixW    = 6;
  localparam int DigitW    = 6;
  localparam int CharW     = 8;
  localparam int LenW      = 6;
  localparam int MaxDigits = 32;
  localparam int DigitIdxW = $clog2(MaxDigits);
  localparam int DigitCntW = $clog2(MaxDigits + 1);
  localparam int DivCntW   = $clog2(DataW);
  localparam int AddrW     = 3;
  localparam int ApbDataW  = 32;

  localparam logic [RadixW-1:0] RadixReset = 6'd10;
  localparam logic [RadixW-1:0] RadixDec   = 6'd10;
  localparam logic [RadixW-1:0] RadixMin   = 6'd2;
  localparam logic [RadixW-1:0] RadixMax   = 6'd36;

  localparam logic [CharW-1:0] CharZero  = 8'h30;
  localparam logic [CharW-1:0] CharA     = 8'h61;
  localparam logic [CharW-1:0] CharMinus = 8'h2d;

  // Register index as decoded from paddr[2].
  localparam logic RegRadix = 1'b0;

  // Out-of-range radix codes saturate to the nearest legal base.
  function automatic logic [RadixW-1:0] eff_radix(input logic [RadixW-1:0] r);
    logic [RadixW-1:0] res;
    res = r;
    if (r < RadixMin) res = RadixMin;
    if (r > RadixMax) res = RadixMax;
    return res;
  endfunction

  function automatic logic [CharW-1:0] digit_char(input logic [DigitW-1:0] d);
    logic [CharW-1:0] dw;
    dw = {{(CharW-DigitW){1'b0}}, d};
    if (d < DigitW'(10)) return CharZero + dw;
    return CharA + dw - CharW'(10);
  endfunction

endpackage

// ===== sv/itra_apb_regs.sv =====
// ----------------------------------------------------------------------------
// itra_apb_regs: configuration register port
// Holds the radix register behind an APB-style slave with no wait states.
// ----------------------------------------------------------------------------
module itra_apb_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [itra_pkg::AddrW-1:0]         paddr,
  input  logic [itra_pkg::ApbDataW-1:0]      pwdata,
  output logic [itra_pkg::ApbDataW-1:0]      prdata,
  output logic                               pready,
  output logic [itra_pkg::RadixW-1:0]        radix_o
);

  logic [itra_pkg::RadixW-1:0] radix_q, radix_d;
  logic                        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == itra_pkg::RegRadix);

  always_comb begin
    radix_d = radix_q;
    if (wr_en) radix_d = pwdata[itra_pkg::RadixW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= itra_pkg::RadixReset;
    end else begin
      radix_q <= radix_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == itra_pkg::RegRadix) begin
      prdata = {{(itra_pkg::ApbDataW-itra_pkg::RadixW){1'b0}}, radix_q};
    end
  end

  assign radix_o = radix_q;

endmodule

// ===== sv/itra_divider.sv =====
// ----------------------------------------------------------------------------
// itra_divider: bit-serial restoring divider
// Divides a 32-bit word by a small radix, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module itra_divider (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [itra_pkg::DataW-1:0]         dividend_i,
  input  logic [itra_pkg::RadixW-1:0]        divisor_i,
  output logic                               done_o,
  output logic [itra_pkg::DataW-1:0]         quotient_o,
  output logic [itra_pkg::DigitW-1:0]        remainder_o
);

  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [itra_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic [itra_pkg::DataW-1:0]   qr_q, qr_d;
  logic [itra_pkg::DigitW-1:0]  rem_q, rem_d;
  logic [itra_pkg::RadixW-1:0]  div_q, div_d;
  logic [itra_pkg::DigitW:0]    trial;
  logic [itra_pkg::DigitW:0]    diff;
  logic                         ge;

  // The remainder stays below the divisor, so the shifted trial fits in
  // one extra bit and the difference fits back into the remainder.
  assign trial = {rem_q, qr_q[itra_pkg::DataW-1]};
  assign ge    = trial >= {1'b0, div_q};
  assign diff  = trial - {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    qr_d   = qr_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      qr_d   = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      qr_d  = {qr_q[itra_pkg::DataW-2:0], ge};
      rem_d = ge ? diff[itra_pkg::DigitW-1:0] : trial[itra_pkg::DigitW-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == itra_pkg::DivCntW'(itra_pkg::DataW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qr_q  <= qr_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = qr_q;
  assign remainder_o = rem_q;

endmodule

// ===== sv/integer_to_radix_ascii_top.sv =====
// ----------------------------------------------------------------------------
// integer_to_radix_ascii_top: integer to radix ASCII converter
// Converts a 32-bit integer into text in a configurable radix, one
// character per output transfer, most significant character first.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Payload
//  input     in         in_valid_i / in_stall_o   value_i
//  output    out        out_valid_o / out_stall_i character_o, length_o, last_o
//  config    in         psel/penable/pwrite       paddr, pwdata, prdata
//
// All digits are first worked out in the bit-serial divider, least significant
// first; each is then read back from the digit buffer (StRd) and loaded into
// the output register (StLoad), after a leading minus (StSign) where there is
// one. The divider yields one quotient bit per cycle.
// Reset clears the control state; the digit buffer needs no clearing.
// The next item is accepted once the last character sits in the output
// register, while that character may still be stalled.
// ----------------------------------------------------------------------------
module integer_to_radix_ascii_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic signed [itra_pkg::DataW-1:0]  value_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  output logic [itra_pkg::CharW-1:0]         character_o,
  output logic [itra_pkg::LenW-1:0]          length_o,
  output logic                               last_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [itra_pkg::AddrW-1:0]         paddr,
  input  logic [itra_pkg::ApbDataW-1:0]      pwdata,
  output logic [itra_pkg::ApbDataW-1:0]      prdata,
  output logic                               pready
);

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StDiv  = 5'b00010,
    StSign = 5'b00100,
    StRd   = 5'b01000,
    StLoad = 5'b10000
  } state_e;

  state_e                         state_q, state_d;
  logic [itra_pkg::RadixW-1:0]    radix_cfg;
  logic [itra_pkg::RadixW-1:0]    rad_q, rad_d, rad_in;
  logic                           neg_q, neg_d, neg_in;
  logic [itra_pkg::DataW-1:0]     raw, mag;
  logic [itra_pkg::DigitCntW-1:0] cnt_q, cnt_d;
  logic [itra_pkg::LenW-1:0]      len_q, len_d;
  logic [itra_pkg::DigitW-1:0]    rd_data_q;
  logic [itra_pkg::DigitW-1:0]    dig_mem [itra_pkg::MaxDigits];
  logic                           accept;
  logic                           out_free;
  logic                           div_start, div_done;
  logic [itra_pkg::DataW-1:0]     div_dividend, div_quot;
  logic [itra_pkg::RadixW-1:0]    div_divisor;
  logic [itra_pkg::DigitW-1:0]    div_rem;
  logic                           div_more;
  logic                           mem_we;
  logic                           rd_en;
  logic                           ov_q, ov_d;
  logic [itra_pkg::CharW-1:0]     ch_q, ch_d;
  logic [itra_pkg::LenW-1:0]      ol_q, ol_d;
  logic                           last_q, last_d;
  logic                           load;

  itra_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .radix_o (radix_cfg)
  );

  itra_divider u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .done_o      (div_done),
    .quotient_o  (div_quot),
    .remainder_o (div_rem)
  );

  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !ov_q || !out_stall_i;

  // Only base ten shows a sign; every other base reads the word unsigned.
  assign raw    = value_i;
  assign rad_in = itra_pkg::eff_radix(radix_cfg);
  assign neg_in = (rad_in == itra_pkg::RadixDec) && raw[itra_pkg::DataW-1];
  assign mag    = neg_in ? (~raw + 1'b1) : raw;

  assign div_more = (div_quot != '0) &&
                    (cnt_q != itra_pkg::DigitCntW'(itra_pkg::MaxDigits - 1));
  assign mem_we   = (state_q == StDiv) && div_done;
  assign rd_en    = (state_q == StRd);

  assign div_start    = accept || (mem_we && div_more);
  assign div_dividend = accept ? mag : div_quot;
  assign div_divisor  = accept ? rad_in : rad_q;

  always_comb begin
    state_d = state_q;
    rad_d   = rad_q;
    neg_d   = neg_q;
    cnt_d   = cnt_q;
    len_d   = len_q;
    load    = 1'b0;
    ch_d    = ch_q;
    ol_d    = ol_q;
    last_d  = last_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          rad_d   = rad_in;
          neg_d   = neg_in;
          cnt_d   = '0;
          state_d = StDiv;
        end
      end
      StDiv: begin
        if (div_done) begin
          cnt_d = cnt_q + 1'b1;
          if (!div_more) begin
            len_d   = itra_pkg::LenW'(cnt_q + 1'b1 + neg_q);
            state_d = neg_q ? StSign : StRd;
          end
        end
      end
      StSign: begin
        if (out_free) begin
          load    = 1'b1;
          ch_d    = itra_pkg::CharMinus;
          ol_d    = len_q;
          last_d  = 1'b0;
          state_d = StRd;
        end
      end
      StRd: begin
        state_d = StLoad;
      end
      StLoad: begin
        if (out_free) begin
          load    = 1'b1;
          ch_d    = itra_pkg::digit_char(rd_data_q);
          ol_d    = len_q;
          last_d  = (cnt_q == itra_pkg::DigitCntW'(1));
          cnt_d   = cnt_q - 1'b1;
          state_d = (cnt_q == itra_pkg::DigitCntW'(1)) ? StIdle : StRd;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    ov_d = ov_q;
    if (load) begin
      ov_d = 1'b1;
    end else if (!out_stall_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      rad_q   <= itra_pkg::RadixReset;
      neg_q   <= 1'b0;
      cnt_q   <= '0;
      len_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      rad_q   <= rad_d;
      neg_q   <= neg_d;
      cnt_q   <= cnt_d;
      len_q   <= len_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q   <= ch_d;
    ol_q   <= ol_d;
    last_q <= last_d;
  end

  // Digit buffer: least significant digit at entry zero, read back in
  // reverse order through a registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      dig_mem[cnt_q[itra_pkg::DigitIdxW-1:0]] <= div_rem;
    end
  end

  logic [itra_pkg::DigitCntW-1:0] rd_ptr;
  assign rd_ptr = cnt_q - 1'b1;

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= dig_mem[rd_ptr[itra_pkg::DigitIdxW-1:0]];
    end
  end

  assign out_valid_o = ov_q;
  assign character_o = ch_q;
  assign length_o    = ol_q;
  assign last_o      = last_q;

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == StDiv)
    else $error("divider finished outside the division phase");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StLoad && out_free && cnt_q == itra_pkg::DigitCntW'(1))
      |=> (state_q == StIdle && out_valid_o && last_o))
    else $error("final character did not close the string");

  a_radix_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != StIdle |-> (rad_q >= itra_pkg::RadixMin && rad_q <= itra_pkg::RadixMax))
    else $error("working radix out of range");

  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> length_o != '0)
    else $error("output transfer with zero length");

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for integer_to_radix_ascii_top
// Sends integers through the input channel under several radix settings and
// compares every character transfer with expected text, given directly or from a local model of the conversion.
// ----------------------------------------------------------------------------
module testbench;

  localparam int                         ClkHalf     = 4;
  localparam int                         LimitCycles = 3_000_000;
  localparam int                         DrainCycles = 50;
  localparam int                         PhaseItems  = 28;
  localparam int                         PhaseCount  = 12;
  localparam logic [itra_pkg::AddrW-1:0] RadixAddr   = '0;

  typedef struct packed {
    logic [itra_pkg::CharW-1:0] ch;
    logic [itra_pkg::LenW-1:0]  len;
    logic                       last;
  } char_xfer_t;

  typedef struct {
    logic [itra_pkg::RadixW-1:0] radix;
    logic [itra_pkg::DataW-1:0]  value;
    string                       text;   // empty when the local model supplies the text
  } directed_row_t;

  logic                              clk_i;
  logic                              rst_ni;
  logic signed [itra_pkg::DataW-1:0] value_i;
  logic                              in_valid_i;
  logic                              in_stall_o;
  logic [itra_pkg::CharW-1:0]        character_o;
  logic [itra_pkg::LenW-1:0]         length_o;
  logic                              last_o;
  logic                              out_valid_o;
  logic                              out_stall_i;
  logic                              psel;
  logic                              penable;
  logic                              pwrite;
  logic [itra_pkg::AddrW-1:0]        paddr;
  logic [itra_pkg::ApbDataW-1:0]     pwdata;
  logic [itra_pkg::ApbDataW-1:0]     prdata;
  logic                              pready;

  char_xfer_t                  pending_chars[$];
  logic [itra_pkg::RadixW-1:0] radix_setting;
  int unsigned                 mismatch_count;
  int unsigned                 cycle_count;
  bit                          sender_calm;
  bit                          receiver_calm;

  integer_to_radix_ascii_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (value_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .character_o (character_o),
    .length_o    (length_o),
    .last_o      (last_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial clk_i = 1'b0;
  always #(ClkHalf) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LimitCycles) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Waits of either side come in bursts, with occasional stretches of none.
  function automatic int unsigned draw_wait(ref bit calm);
    if ($urandom_range(0, 29) == 0) calm = ~calm;
    return calm ? 0 : $urandom_range(0, 5);
  endfunction

  function automatic void expect_text(input string s);
    char_xfer_t x;
    for (int i = 0; i < s.len(); i++) begin
      x.ch   = s[i];
      x.len  = itra_pkg::LenW'(s.len());
      x.last = (i == s.len() - 1);
      pending_chars.push_back(x);
    end
  endfunction

  // Divides down to digits, least significant first, then queues the
  // characters most significant first with an optional leading minus.
  function automatic void convert_value(input logic [itra_pkg::RadixW-1:0] radix_code,
                                        input logic [itra_pkg::DataW-1:0] v);
    logic [itra_pkg::RadixW-1:0] base;
    logic [itra_pkg::DataW-1:0]  mag;
    logic [itra_pkg::DigitW-1:0] digits[itra_pkg::MaxDigits];
    int                          n;
    logic                        neg;
    logic [itra_pkg::LenW-1:0]   total;
    char_xfer_t                  x;
    int                          k;
    base = radix_code;
    if (radix_code < itra_pkg::RadixMin) base = itra_pkg::RadixMin;
    if (radix_code > itra_pkg::RadixMax) base = itra_pkg::RadixMax;
    neg = (base == itra_pkg::RadixDec) && v[itra_pkg::DataW-1];
    mag = neg ? (~v + 1'b1) : v;
    n = 0;
    do begin
      digits[n] = itra_pkg::DigitW'(mag % base);
      mag = mag / base;
      n++;
    end while (mag != 0);
    total = itra_pkg::LenW'(n + neg);
    k = 0;
    if (neg) begin
      x.ch   = itra_pkg::CharMinus;
      x.len  = total;
      x.last = (total == 1);
      pending_chars.push_back(x);
      k = 1;
    end
    for (int i = n - 1; i >= 0; i--) begin
      x.ch   = (digits[i] < 10) ? itra_pkg::CharZero + itra_pkg::CharW'(digits[i])
                                : itra_pkg::CharA + itra_pkg::CharW'(digits[i])
                                  - itra_pkg::CharW'(10);
      x.len  = total;
      x.last = (k + 1 == total);
      pending_chars.push_back(x);
      k++;
    end
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_value(input logic [itra_pkg::DataW-1:0] v, input string text);
    int unsigned gap;
    gap = draw_wait(sender_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    value_i    <= v;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    if (text.len() > 0) expect_text(text);
    else convert_value(radix_setting, v);
    @(negedge clk_i);
  endtask

  // Makes the block idle first: drops the input and waits until every character is received.
  task automatic write_radix(input logic [itra_pkg::RadixW-1:0] r);
    in_valid_i <= 1'b0;
    while (pending_chars.size() != 0) @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RadixAddr;
    pwdata  <= {(itra_pkg::ApbDataW - itra_pkg::RadixW - 1)'(
                  $urandom_range(0, (1 << (itra_pkg::ApbDataW - itra_pkg::RadixW - 1)) - 1)),
                1'b0, r};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    radix_setting = r;
  endtask

  function automatic logic [itra_pkg::DataW-1:0] random_value();
    case ($urandom_range(0, 5))
      0: return itra_pkg::DataW'($urandom_range(0, 100));
      1: return -itra_pkg::DataW'($urandom_range(1, 100));
      2: begin
        case ($urandom_range(0, 4))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'hffff_ffff;
          3: return 32'h0000_0001;
          default: return '0;
        endcase
      end
      3: return $urandom >> $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // Receiver: stall for a drawn number of cycles, then wait for a transfer.
  initial begin
    int unsigned n;
    out_stall_i = 1'b1;
    receiver_calm = 1'b0;
    forever begin
      @(negedge clk_i);
      n = draw_wait(receiver_calm);
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  always @(posedge clk_i) begin
    char_xfer_t  exp_x;
    int unsigned errs;
    errs = 0;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected character transfer %h len %0d last %b",
                 $time, character_o, length_o, last_o);
        errs++;
      end else begin
        exp_x = pending_chars.pop_front();
        if (character_o !== exp_x.ch) begin
          $display("%0t: character expected %h got %h", $time, exp_x.ch, character_o);
          errs++;
        end
        if (length_o !== exp_x.len) begin
          $display("%0t: length expected %0d got %0d", $time, exp_x.len, length_o);
          errs++;
        end
        if (last_o !== exp_x.last) begin
          $display("%0t: last expected %b got %b", $time, exp_x.last, last_o);
          errs++;
        end
      end
    end
    if (errs != 0) mismatch_count <= mismatch_count + errs;
  end

  initial begin
    directed_row_t               rows[$];
    logic [itra_pkg::RadixW-1:0] phase_radix[$];
    logic [itra_pkg::RadixW-1:0] r;
    rows = '{
      '{6'd10, 32'd0,          "0"},
      '{6'd10, 32'hffff_ffff,  "-1"},
      '{6'd10, 32'h8000_0000,  "-2147483648"},
      '{6'd10, 32'h7fff_ffff,  "2147483647"},
      '{6'd10, 32'd9,          "9"},
      '{6'd10, 32'd10,         "10"},
      '{6'd10, 32'd12345,      ""},
      '{6'd10, -32'sd987654321, ""},
      '{6'd16, 32'hffff_ffff,  "ffffffff"},
      '{6'd16, 32'h8000_0000,  "80000000"},
      '{6'd16, 32'hdead_beef,  "deadbeef"},
      '{6'd2,  32'hffff_ffff,  "11111111111111111111111111111111"},
      '{6'd2,  32'd0,          "0"},
      '{6'd2,  32'h8000_0000,  "10000000000000000000000000000000"},
      '{6'd36, 32'd35,         "z"},
      '{6'd36, 32'd36,         "10"},
      '{6'd36, 32'hffff_ffff,  ""},
      '{6'd0,  32'd5,          "101"},
      '{6'd1,  32'hffff_ffff,  "11111111111111111111111111111111"},
      '{6'd37, 32'd35,         "z"},
      '{6'd63, 32'd36,         "10"},
      '{6'd63, 32'hffff_ffff,  ""},
      '{6'd8,  32'hffff_ffff,  "37777777777"},
      '{6'd11, 32'hffff_ffff,  ""},
      '{6'd3,  32'h1234_5678,  ""}
    };
    phase_radix = '{6'd2, 6'd36, 6'd10, 6'd16, 6'd0, 6'd63, 6'd1, 6'd37};

    rst_ni         = 1'b0;
    value_i        = '0;
    in_valid_i     = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    mismatch_count = 0;
    cycle_count    = 0;
    sender_calm    = 1'b0;
    radix_setting  = itra_pkg::RadixReset;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // The first rows run on the reset radix without any register write.
    foreach (rows[i]) begin
      if (rows[i].radix != radix_setting) write_radix(rows[i].radix);
      send_value(rows[i].value, rows[i].text);
    end

    for (int p = 0; p < PhaseCount; p++) begin
      r = (p < phase_radix.size()) ? phase_radix[p]
                                   : itra_pkg::RadixW'($urandom_range(0, 63));
      write_radix(r);
      repeat (PhaseItems) send_value(random_value(), "");
    end

    in_valid_i <= 1'b0;
    while (pending_chars.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (mismatch_count == 0 && pending_chars.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
